>>> sv/sparse_table_range_min_query_assert.svh
// Assertion macros for the range-minimum engine.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef SPARSE_TABLE_RANGE_MIN_QUERY_ASSERT_SVH
`define SPARSE_TABLE_RANGE_MIN_QUERY_ASSERT_SVH

// Antecedent implies consequent in the same cycle
`define STRMQ_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the following cycle
`define STRMQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/strmq_pkg.sv
// ----------------------------------------------------------------------------
// strmq_pkg
// Shared constants, state encoding and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package strmq_pkg;

    localparam int DEPTH     = 1024;
    localparam int IDX_W     = 10;
    localparam int POS_W     = 11;
    localparam int VALUE_W   = 32;
    localparam int LVL_W     = 4;
    localparam int NUM_LVL   = 9;
    localparam int TBL_AW    = LVL_W + IDX_W;
    localparam int TBL_DEPTH = NUM_LVL * DEPTH;

    localparam logic [LVL_W-1:0] LAST_LVL = LVL_W'(NUM_LVL - 1);

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_B_DIR,
        ST_B_TRD,
        ST_B_TAB,
        ST_B_ERD,
        ST_B_WR,
        ST_Q_CHK,
        ST_Q_DIR,
        ST_Q_TRD,
        ST_Q_TAB,
        ST_Q_ERD,
        ST_Q_OUT,
        ST_Q_ERR
    } state_t;

    typedef struct packed {
        logic load_we;
        logic set_len;
        logic ready_set;
        logic ready_clr;
        logic capture;
        logic q_mode;
        logic ab_direct;
        logic ab_table;
        logic tbl_we;
        logic ctr_clr;
        logic ctr_step;
        logic out_load;
        logic out_err;
    } cmd_t;

    typedef struct packed {
        logic last_i;
        logic last_lvl;
        logic lvl_zero;
        logic q_err;
        logic q_short;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

>>> sv/strmq_datapath.sv
// ----------------------------------------------------------------------------
// strmq_datapath
// Element store, sparse table memory, build counters and query arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

module strmq_datapath
    import strmq_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire cmd_t                      cmd,
    output sts_t                           sts,
    input  wire logic [IDX_W-1:0]          elem_index,
    input  wire logic signed [VALUE_W-1:0] elem_value,
    input  wire logic [POS_W-1:0]          range_begin,
    input  wire logic [POS_W-1:0]          range_end,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic [IDX_W-1:0]               min_index,
    output logic signed [VALUE_W-1:0]      min_value,
    output logic                           query_error
);

    logic signed [VALUE_W-1:0] elem_mem [0:DEPTH-1];
    logic [IDX_W-1:0]          tbl_mem  [0:TBL_DEPTH-1];

    logic [POS_W-1:0]          len_reg;
    logic                      ready_reg;
    logic [POS_W-1:0]          qb_reg;
    logic [POS_W-1:0]          qe_reg;
    logic [LVL_W-1:0]          lvl_reg;
    logic [IDX_W-1:0]          i_reg;
    logic [IDX_W-1:0]          ra_reg;
    logic [IDX_W-1:0]          rb_reg;
    logic [IDX_W-1:0]          a_reg;
    logic [IDX_W-1:0]          b_reg;
    logic signed [VALUE_W-1:0] va_reg;
    logic signed [VALUE_W-1:0] vb_reg;
    logic                      out_valid_reg;

    logic [TBL_AW-1:0]         ta;
    logic [TBL_AW-1:0]         tb;
    logic [IDX_W-1:0]          da;
    logic [IDX_W-1:0]          db;
    logic [POS_W-1:0]          span;
    logic [IDX_W-1:0]          len1;
    logic [LVL_W-1:0]          qw;
    logic [LVL_W-1:0]          qlvl;
    logic [IDX_W-1:0]          q_ta_idx;
    logic [IDX_W-1:0]          q_tb_idx;
    logic                      q_two;
    logic                      less;

    // Query decode: two-element range, table level and table indices
    always_comb
    begin
        len1 = IDX_W'(qe_reg - qb_reg - POS_W'(1));
        qw   = '0;
        for (int k = 0; k < IDX_W; k++)
        begin
            if (len1[k])
            begin
                qw = LVL_W'(k);
            end
        end
        q_two    = ((POS_W+1)'(qb_reg) + (POS_W+1)'(2)) == (POS_W+1)'(qe_reg);
        q_ta_idx = IDX_W'(qe_reg - POS_W'(1));
        if (q_two)
        begin
            qlvl     = '0;
            q_tb_idx = q_ta_idx;
        end
        else
        begin
            qlvl     = qw - LVL_W'(1);
            q_tb_idx = IDX_W'(qb_reg + (POS_W'(1) << qw) - POS_W'(1));
        end
    end

    // Table read addresses for build and query
    always_comb
    begin
        span = POS_W'(1) << lvl_reg;
        if (cmd.q_mode)
        begin
            ta = {qlvl, q_ta_idx};
            tb = {qlvl, q_tb_idx};
            da = qb_reg[IDX_W-1:0];
            db = qb_reg[IDX_W-1:0];
        end
        else
        begin
            ta = {lvl_reg - LVL_W'(1), i_reg};
            if (POS_W'(i_reg) >= span)
            begin
                tb = {lvl_reg - LVL_W'(1), IDX_W'(POS_W'(i_reg) - span)};
            end
            else
            begin
                tb = {lvl_reg - LVL_W'(1), IDX_W'(0)};
            end
            da = i_reg;
            db = (i_reg == '0) ? '0 : i_reg - IDX_W'(1);
        end
    end

    // Ties go to b, the left candidate
    assign less = va_reg < vb_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_we)
        begin
            elem_mem[elem_index] <= elem_value;
        end
        va_reg <= elem_mem[a_reg];
        vb_reg <= elem_mem[b_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.tbl_we)
        begin
            tbl_mem[{lvl_reg, i_reg}] <= less ? a_reg : b_reg;
        end
        ra_reg <= tbl_mem[ta];
        rb_reg <= tbl_mem[tb];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            qb_reg <= range_begin;
            qe_reg <= range_end;
        end
        priority if (cmd.ab_direct)
        begin
            a_reg <= da;
            b_reg <= db;
        end
        else if (cmd.ab_table)
        begin
            a_reg <= ra_reg;
            b_reg <= rb_reg;
        end
        if (cmd.out_load)
        begin
            if (cmd.out_err)
            begin
                min_index   <= '0;
                min_value   <= '0;
                query_error <= 1'b1;
            end
            else
            begin
                min_index   <= less ? a_reg : b_reg;
                min_value   <= (sts.q_short && qb_reg[IDX_W]) ? '0 : (less ? va_reg : vb_reg);
                query_error <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            ready_reg     <= 1'b0;
            lvl_reg       <= '0;
            i_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.set_len)
            begin
                len_reg <= POS_W'(elem_index) + POS_W'(1);
            end
            priority if (cmd.ready_set)
            begin
                ready_reg <= 1'b1;
            end
            else if (cmd.ready_clr)
            begin
                ready_reg <= 1'b0;
            end
            priority if (cmd.ctr_clr)
            begin
                lvl_reg <= '0;
                i_reg   <= '0;
            end
            else if (cmd.ctr_step)
            begin
                if (sts.last_i)
                begin
                    lvl_reg <= lvl_reg + LVL_W'(1);
                    i_reg   <= '0;
                end
                else
                begin
                    i_reg <= i_reg + IDX_W'(1);
                end
            end
            // hold the result until its transfer completes
            priority if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;

    always_comb
    begin
        sts.last_i   = (POS_W'(i_reg) + POS_W'(1)) == len_reg;
        sts.last_lvl = lvl_reg == LAST_LVL;
        sts.lvl_zero = lvl_reg == '0;
        sts.q_err    = !ready_reg || (qe_reg > len_reg);
        sts.q_short  = ((POS_W+1)'(qe_reg)) <= ((POS_W+1)'(qb_reg) + (POS_W+1)'(1));
        sts.out_free = !out_valid_reg || !out_stall;
    end

endmodule

`default_nettype wire

>>> sv/strmq_ctrl.sv
// ----------------------------------------------------------------------------
// strmq_ctrl
// Sequencer for loads, the table build sweep and queries.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sparse_table_range_min_query_assert.svh"

module strmq_ctrl
    import strmq_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_stall,
    input  wire logic opcode,
    input  wire logic last_elem,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_stall = state_reg != ST_IDLE;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (opcode == OP_QUERY)
                    begin
                        state_next = ST_Q_CHK;
                    end
                    else if (last_elem)
                    begin
                        state_next = ST_B_DIR;
                    end
                end
            end
            ST_B_DIR: state_next = ST_B_ERD;
            ST_B_TRD: state_next = ST_B_TAB;
            ST_B_TAB: state_next = ST_B_ERD;
            ST_B_ERD: state_next = ST_B_WR;
            ST_B_WR:
            begin
                priority if (sts.last_i && sts.last_lvl)
                begin
                    state_next = ST_IDLE;
                end
                else if (sts.last_i || !sts.lvl_zero)
                begin
                    state_next = ST_B_TRD;
                end
                else
                begin
                    state_next = ST_B_DIR;
                end
            end
            ST_Q_CHK:
            begin
                priority if (sts.q_err)
                begin
                    state_next = ST_Q_ERR;
                end
                else if (sts.q_short)
                begin
                    state_next = ST_Q_DIR;
                end
                else
                begin
                    state_next = ST_Q_TRD;
                end
            end
            ST_Q_DIR: state_next = ST_Q_ERD;
            ST_Q_TRD: state_next = ST_Q_TAB;
            ST_Q_TAB: state_next = ST_Q_ERD;
            ST_Q_ERD: state_next = ST_Q_OUT;
            ST_Q_OUT, ST_Q_ERR:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (opcode == OP_QUERY)
                    begin
                        cmd.capture = 1'b1;
                    end
                    else
                    begin
                        cmd.load_we   = 1'b1;
                        cmd.ready_clr = 1'b1;
                        cmd.set_len   = last_elem;
                        cmd.ctr_clr   = last_elem;
                    end
                end
            end
            ST_B_DIR: cmd.ab_direct = 1'b1;
            ST_B_TAB: cmd.ab_table = 1'b1;
            ST_B_WR:
            begin
                cmd.tbl_we = 1'b1;
                if (sts.last_i && sts.last_lvl)
                begin
                    cmd.ready_set = 1'b1;
                end
                else
                begin
                    cmd.ctr_step = 1'b1;
                end
            end
            ST_Q_DIR:
            begin
                cmd.q_mode    = 1'b1;
                cmd.ab_direct = 1'b1;
            end
            ST_Q_TRD: cmd.q_mode = 1'b1;
            ST_Q_TAB:
            begin
                cmd.q_mode   = 1'b1;
                cmd.ab_table = 1'b1;
            end
            ST_Q_OUT:
            begin
                cmd.q_mode   = 1'b1;
                cmd.out_load = sts.out_free;
            end
            ST_Q_ERR:
            begin
                cmd.out_load = sts.out_free;
                cmd.out_err  = 1'b1;
            end
            default: cmd = '0;
        endcase
    end

    `STRMQ_ASSERT_SAME(a_out_free, cmd.out_load, sts.out_free, "result loaded over a pending one")
    `STRMQ_ASSERT_SAME(a_we_excl, cmd.tbl_we, !cmd.out_load && !cmd.load_we, "table write overlaps")
    `STRMQ_ASSERT_NEXT(a_q_start, accept && (opcode == OP_QUERY), state_reg == ST_Q_CHK, "query lost")
    `STRMQ_ASSERT_SAME(a_ready_end, cmd.ready_set, sts.last_i && sts.last_lvl, "early ready")

endmodule

`default_nettype wire

>>> sv/sparse_table_range_min_query.sv
// ----------------------------------------------------------------------------
// sparse_table_range_min_query
// Range-minimum engine over a sparse table of leftmost-minimum indices.
// ----------------------------------------------------------------------------
// The load marked last starts a build that sweeps nine table levels of
// 'length' entries each, with stall held high throughout. Level zero steps
// through index load, element read and write per entry; every higher level
// steps through table read, index load, element read and write. A query holds
// stall through its check, table or direct index load, element read and output
// states, or through check and error state for an error, plus any wait for the
// previous result to leave. The registered reads of the table and element
// memories account for the separate read states.
`default_nettype none

module sparse_table_range_min_query
    import strmq_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic                      opcode,
    input  wire logic [IDX_W-1:0]          elem_index,
    input  wire logic signed [VALUE_W-1:0] elem_value,
    input  wire logic                      last_elem,
    input  wire logic [POS_W-1:0]          range_begin,
    input  wire logic [POS_W-1:0]          range_end,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic [IDX_W-1:0]               min_index,
    output logic signed [VALUE_W-1:0]      min_value,
    output logic                           query_error
);

    cmd_t cmd;
    sts_t sts;

    strmq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .opcode    (opcode),
        .last_elem (last_elem),
        .sts       (sts),
        .cmd       (cmd)
    );

    strmq_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .elem_index  (elem_index),
        .elem_value  (elem_value),
        .range_begin (range_begin),
        .range_end   (range_end),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .min_index   (min_index),
        .min_value   (min_value),
        .query_error (query_error)
    );

endmodule

`default_nettype wire

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the sparse-table range-minimum engine against its own predictor:
// directed loads and queries first, then random builds of mixed sizes with
// query bursts, with random idling on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    import strmq_pkg::*;

    typedef struct {
        logic                      op;
        logic [IDX_W-1:0]          idx;
        logic signed [VALUE_W-1:0] val;
        logic                      last;
        logic [POS_W-1:0]          rb;
        logic [POS_W-1:0]          re;
    } item_t;

    typedef struct {
        logic [IDX_W-1:0]          idx;
        logic signed [VALUE_W-1:0] val;
        logic                      err;
    } answer_t;

    class rmq_scoreboard;
        logic signed [VALUE_W-1:0] store [DEPTH];
        int unsigned               levels [16][DEPTH];
        int unsigned               length;
        bit                        built;
        answer_t                   answers [$];
        int                        errors;

        function new();
            length = 0;
            built  = 0;
            errors = 0;
            foreach (store[i]) store[i] = '0;
        endfunction

        function void build_levels(int unsigned n);
            int unsigned a, b, span;
            levels[0][0] = 0;
            for (int unsigned i = 1; i < n; i++)
                levels[0][i] = (store[i] < store[i-1]) ? i : i - 1;
            for (int unsigned w = 1; w < 16; w++) begin
                span = 1 << w;
                for (int unsigned i = 0; i < n; i++) begin
                    a = levels[w-1][i];
                    b = levels[w-1][(i >= span) ? i - span : 0];
                    levels[w][i] = (store[a % DEPTH] < store[b % DEPTH]) ? a : b;
                end
            end
        endfunction

        // Note an accepted transfer on the input side
        function void note_input(item_t it);
            answer_t     ans;
            int unsigned b, e, len1, w, a, c, pos;
            if (it.op == OP_LOAD) begin
                store[it.idx] = it.val;
                built = 0;
                if (it.last) begin
                    length = it.idx + 1;
                    build_levels(length);
                    built = 1;
                end
                return;
            end
            b = it.rb;
            e = it.re;
            if (!built || e > length) begin
                ans.idx = '0;
                ans.val = '0;
                ans.err = 1'b1;
                answers.push_back(ans);
                return;
            end
            if (b + 1 >= e)
                pos = b;
            else if (b + 2 == e)
                pos = levels[0][e-1];
            else begin
                len1 = e - b - 1;
                w = 0;
                while (w < 31 && (len1 >> (w + 1)) != 0)
                    w++;
                a = levels[(w-1) % 16][(e-1) % DEPTH];
                c = levels[(w-1) % 16][(b + (1 << w) - 1) % DEPTH];
                pos = (store[a % DEPTH] < store[c % DEPTH]) ? a : c;
            end
            ans.idx = pos[IDX_W-1:0];
            ans.val = (pos < DEPTH) ? store[pos] : '0;
            ans.err = 1'b0;
            answers.push_back(ans);
        endfunction

        task report(string what, longint got, longint want);
            $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
            errors++;
        endtask

        task check_result(logic [IDX_W-1:0] idx, logic signed [VALUE_W-1:0] val,
                          logic err);
            answer_t want;
            if (answers.size() == 0) begin
                report("unexpected result, index", idx, -1);
                return;
            end
            want = answers.pop_front();
            if (err !== want.err) report("query_error", err, want.err);
            if (idx !== want.idx) report("min_index", idx, want.idx);
            if (val !== want.val) report("min_value", val, want.val);
        endtask

        function int pending();
            return answers.size();
        endfunction
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    logic                      opcode;
    logic [IDX_W-1:0]          elem_index;
    logic signed [VALUE_W-1:0] elem_value;
    logic                      last_elem;
    logic [POS_W-1:0]          range_begin;
    logic [POS_W-1:0]          range_end;
    logic                      out_valid;
    logic                      out_stall;
    logic [IDX_W-1:0]          min_index;
    logic signed [VALUE_W-1:0] min_value;
    logic                      query_error;

    rmq_scoreboard sb;
    int unsigned   cur_len;
    bit            cur_built;
    bit            quiet;
    int            stall_left;

    sparse_table_range_min_query dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .opcode      (opcode),
        .elem_index  (elem_index),
        .elem_value  (elem_value),
        .last_elem   (last_elem),
        .range_begin (range_begin),
        .range_end   (range_end),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .min_index   (min_index),
        .min_value   (min_value),
        .query_error (query_error)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // Input transfers feed the predictor; output transfers are checked
    always @(posedge clk)
    begin
        item_t it;
        if (rst_n && in_valid && !in_stall) begin
            it.op   = opcode;
            it.idx  = elem_index;
            it.val  = elem_value;
            it.last = last_elem;
            it.rb   = range_begin;
            it.re   = range_end;
            sb.note_input(it);
        end
        if (rst_n && out_valid && !out_stall)
            sb.check_result(min_index, min_value, query_error);
    end

    // Receiver stall in bursts, with quiet stretches in between
    always @(posedge clk)
    begin
        if (quiet || !rst_n)
            out_stall <= 1'b0;
        else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end
        else if ($urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 4);
            out_stall  <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    task send(item_t it);
        in_valid    <= 1'b1;
        opcode      <= it.op;
        elem_index  <= it.idx;
        elem_value  <= it.val;
        last_elem   <= it.last;
        range_begin <= it.rb;
        range_end   <= it.re;
        do
            @(posedge clk);
        while (in_stall);
        if (it.op == OP_LOAD) begin
            cur_built = it.last;
            if (it.last)
                cur_len = it.idx + 1;
        end
        if (!quiet && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    task load(int unsigned idx, logic signed [VALUE_W-1:0] val, bit last);
        item_t it;
        it.op   = OP_LOAD;
        it.idx  = idx;
        it.val  = val;
        it.last = last;
        it.rb   = $urandom;
        it.re   = $urandom;
        send(it);
    endtask

    task query(int unsigned b, int unsigned e);
        item_t it;
        it.op   = OP_QUERY;
        it.idx  = $urandom;
        it.val  = $urandom;
        it.last = $urandom;
        it.rb   = b;
        it.re   = e;
        send(it);
    endtask

    // Values drawn from a narrow band now and then so that ties occur
    function logic signed [VALUE_W-1:0] rand_value();
        case ($urandom_range(0, 3))
            0: return $signed($urandom_range(0, 6)) - 3;
            1: return 32'sh7fffffff - $urandom_range(0, 1);
            2: return 32'sh80000000 + $urandom_range(0, 1);
            default: return $urandom;
        endcase
    endfunction

    task random_query();
        int unsigned b, e, k;
        k = $urandom_range(0, 9);
        if (!cur_built || k == 0) begin
            // error: end past the length, or not built
            if (cur_len < DEPTH)
                e = $urandom_range(cur_len + 1, DEPTH);
            else
                e = $urandom_range(0, DEPTH);
            b = $urandom_range(0, DEPTH);
            if (!cur_built || cur_len < DEPTH)
                query(b, e);
        end
        else if (k == 1) begin
            // short or inverted range on a written position
            b = $urandom_range(0, cur_len - 1);
            e = $urandom_range(0, (b + 1 < cur_len) ? b + 1 : cur_len);
            query(b, e);
        end
        else if (k == 2)
            query(DEPTH, $urandom_range(0, cur_len));
        else begin
            e = $urandom_range(1, cur_len);
            b = $urandom_range(0, e - 1);
            query(b, e);
        end
    endtask

    task build(int unsigned n);
        for (int unsigned i = 0; i + 1 < n; i++)
            load(i, rand_value(), 0);
        load(n - 1, rand_value(), 1);
    endtask

    initial
    begin
        int unsigned n;
        sb          = new();
        rst_n       = 1'b0;
        in_valid    <= 1'b0;
        opcode      <= OP_LOAD;
        elem_index  <= '0;
        elem_value  <= '0;
        last_elem   <= 1'b0;
        range_begin <= '0;
        range_end   <= '0;
        stall_left  = 0;
        quiet       = 0;
        cur_len     = 0;
        cur_built   = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: query before any build, then a small table
        query(0, 1);
        load(0, 32'sh7fffffff, 0);
        load(1, 32'sh80000000, 0);
        load(2, 5, 0);
        load(3, -1, 0);
        load(4, 32'sh80000000, 0);
        load(5, 0, 0);
        load(6, -7, 0);
        load(7, 3, 1);
        query(3, 3);
        query(5, 2);
        query(4, 5);
        query(2, 4);
        query(0, 8);
        query(2, 8);
        query(3, 7);
        query(0, 9);
        query(DEPTH, 0);
        query(DEPTH, DEPTH);
        // a plain load drops the table
        load(2, -9, 0);
        query(0, 8);
        load(7, 3, 1);
        query(0, 8);
        query(1, 4);

        // hold off until every answer is back
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);

        for (int ep = 0; ep < 6; ep++) begin
            if (ep == 2)
                n = DEPTH / 2 + 2 + $urandom_range(0, 6);
            else if ($urandom_range(0, 3) == 0)
                n = $urandom_range(1, 3);
            else
                n = $urandom_range(4, 12);
            if (ep == 5)
                quiet = 1;
            build(n);
            // the widest range reaches the top table level
            if (n > DEPTH / 2)
                query(0, n);
            repeat ($urandom_range(6, 10)) random_query();
            if ($urandom_range(0, 2) == 0) begin
                // broken sequence: stray load, then queries that must fail
                load($urandom_range(0, n - 1), rand_value(), 0);
                repeat (2) random_query();
                load(n - 1, rand_value(), 1);
                repeat (4) random_query();
            end
        end
        in_valid <= 1'b0;
        @(posedge clk);

        while (sb.pending() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #60000000;
        $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
